/* rtl/core/h2r_pkg.sv */
// Package for the HSV to RGB converter: payload structs, pipeline stage
// structs, hue sector codes and fixed-point constants. No dependencies.
package h2r_pkg;

  // Width of saturation, brightness and each color channel.
  localparam int unsigned ChannelBits = 8;
  localparam int unsigned HueBits     = 11;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned SectorBits  = HueBits - FracBits;
  localparam int unsigned WideBits    = ChannelBits + FracBits;
  localparam int unsigned ProdBits    = 2 * ChannelBits;
  localparam int unsigned WideProdBits = 2 * ChannelBits + FracBits;

  // Full scale M = 2^ChannelBits - 1 and the derived rounding constants.
  localparam logic [ChannelBits-1:0] ChMax     = {ChannelBits{1'b1}};
  localparam logic [ChannelBits-1:0] PHalf     = {1'b0, {(ChannelBits-1){1'b1}}};
  localparam logic [WideBits-1:0]    FullScale = {ChMax, {FracBits{1'b0}}};
  localparam logic [WideBits-1:0]    QHalf     = {1'b0, ChMax, {(FracBits-1){1'b0}}};
  localparam logic [FracBits:0]      FracOne   = {1'b1, {FracBits{1'b0}}};
  localparam logic [HueBits-1:0]     HueTop    = 11'd1535;
  localparam logic [FracBits-1:0]    FracTop   = {FracBits{1'b1}};

  typedef enum logic [SectorBits-1:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } h2r_sector_e;

  typedef struct packed {
    logic [HueBits-1:0]     hue;
    logic [ChannelBits-1:0] saturation;
    logic [ChannelBits-1:0] brightness;
  } h2r_in_t;

  typedef struct packed {
    logic [ChannelBits-1:0] red;
    logic [ChannelBits-1:0] green;
    logic [ChannelBits-1:0] blue;
  } h2r_out_t;

  // After the first stage: the three differences that scale brightness.
  typedef struct packed {
    h2r_sector_e            sector;
    logic [ChannelBits-1:0] val;
    logic [ChannelBits-1:0] dp;
    logic [WideBits-1:0]    dq;
    logic [WideBits-1:0]    dt;
  } h2r_diff_t;

  // After the second stage: the unrounded numerators.
  typedef struct packed {
    h2r_sector_e             sector;
    logic [ChannelBits-1:0]  val;
    logic [ProdBits-1:0]     np;
    logic [WideProdBits-1:0] nq;
    logic [WideProdBits-1:0] nt;
  } h2r_prod_t;

  // After the third stage: the rounded levels p, q and t.
  typedef struct packed {
    h2r_sector_e            sector;
    logic [ChannelBits-1:0] val;
    logic [ChannelBits-1:0] p;
    logic [ChannelBits-1:0] q;
    logic [ChannelBits-1:0] t;
  } h2r_level_t;

endpackage

/* rtl/core/h2r_prep.sv */
// First pipeline stage: hue clamp, sector split and saturation products.
// Depends on h2r_pkg.
module h2r_prep import h2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  h2r_in_t   data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output h2r_diff_t data_o
);

  logic      valid_q;
  h2r_diff_t data_q, data_d;

  logic [FracBits-1:0] frac;
  logic [FracBits:0]   frac_comp;
  logic [WideBits-1:0] prod_f;
  logic [WideBits:0]   prod_g;

  assign ready_o = ~valid_q | ready_i;

  always_comb begin
    // A hue above the top of the range behaves as the last step of magenta.
    if (data_i.hue > HueTop) begin
      data_d.sector = SecMagenta;
      frac          = FracTop;
    end else begin
      data_d.sector = h2r_sector_e'(data_i.hue[HueBits-1:FracBits]);
      frac          = data_i.hue[FracBits-1:0];
    end
    frac_comp   = FracOne - {1'b0, frac};
    prod_f      = WideBits'(data_i.saturation) * WideBits'(frac);
    prod_g      = (WideBits+1)'(data_i.saturation) * (WideBits+1)'(frac_comp);
    data_d.val  = data_i.brightness;
    data_d.dp   = ChMax - data_i.saturation;
    data_d.dq   = FullScale - prod_f;
    data_d.dt   = FullScale - prod_g[WideBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/h2r_scale.sv */
// Second pipeline stage: scales brightness by the three differences.
// Depends on h2r_pkg.
module h2r_scale import h2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  h2r_diff_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output h2r_prod_t data_o
);

  logic      valid_q;
  h2r_prod_t data_q, data_d;

  assign ready_o = ~valid_q | ready_i;

  always_comb begin
    data_d.sector = data_i.sector;
    data_d.val    = data_i.val;
    data_d.np     = ProdBits'(data_i.val) * ProdBits'(data_i.dp);
    data_d.nq     = WideProdBits'(data_i.val) * WideProdBits'(data_i.dq);
    data_d.nt     = WideProdBits'(data_i.val) * WideProdBits'(data_i.dt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/h2r_div.sv */
// Third pipeline stage: rounded division of the numerators by full scale.
// Depends on h2r_pkg.
module h2r_div import h2r_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  h2r_prod_t  data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output h2r_level_t data_o
);

  // Exact floor(x / M) for x below M * 2^ChannelBits, by shifts and adds.
  function automatic logic [ChannelBits-1:0] div_by_max(input logic [ProdBits:0] x);
    logic [ProdBits+1:0] sum;
    sum = {1'b0, x} + (ProdBits+2)'(x >> ChannelBits) + (ProdBits+2)'(1);
    return sum[ProdBits-1:ChannelBits];
  endfunction

  logic       valid_q;
  h2r_level_t data_q, data_d;

  logic [ProdBits:0]     xp;
  logic [WideProdBits:0] sum_q, sum_t;

  assign ready_o = ~valid_q | ready_i;

  always_comb begin
    // Dividing by 256*M is a shift by the fraction width, then a divide by M.
    xp    = {1'b0, data_i.np} + (ProdBits+1)'(PHalf);
    sum_q = {1'b0, data_i.nq} + (WideProdBits+1)'(QHalf);
    sum_t = {1'b0, data_i.nt} + (WideProdBits+1)'(QHalf);
    data_d.sector = data_i.sector;
    data_d.val    = data_i.val;
    data_d.p      = div_by_max(xp);
    data_d.q      = div_by_max(sum_q[WideProdBits:FracBits]);
    data_d.t      = div_by_max(sum_t[WideProdBits:FracBits]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/hsv_to_rgb_convert_unit.sv */
// Top level of the HSV to RGB converter: four-stage pipeline and sector routing.
// Depends on h2r_pkg, h2r_prep, h2r_scale and h2r_div.
//
//   Channel | Signals                          | Payload
//   --------+----------------------------------+-----------------------------
//   input   | in_valid_i, in_ready_o           | in_data_i  (hue, sat, value)
//   output  | out_valid_o, out_ready_i         | out_data_o (red, green, blue)
//
// Each transaction passes through the stages in order up to the output register:
// clamp and saturation products, brightness products, rounded division by full
// scale, and sector routing. One transaction is taken per cycle while the
// output side keeps up. Reset clears only the valid bits of the four stages.
// A stall from the output side backs up stage by stage; each stage holds its
// data while full and blocked, and empty stages keep accepting, so bubbles
// close up and nothing is dropped or repeated.
module hsv_to_rgb_convert_unit import h2r_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  h2r_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output h2r_out_t out_data_o
);

  logic       diff_valid, diff_ready;
  h2r_diff_t  diff_data;
  logic       prod_valid, prod_ready;
  h2r_prod_t  prod_data;
  logic       level_valid, level_ready;
  h2r_level_t level_data;

  logic     out_valid_q;
  h2r_out_t out_data_q, out_data_d;

  h2r_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (diff_valid),
    .ready_i (diff_ready),
    .data_o  (diff_data)
  );

  h2r_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_valid),
    .ready_o (diff_ready),
    .data_i  (diff_data),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  h2r_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .valid_o (level_valid),
    .ready_i (level_ready),
    .data_o  (level_data)
  );

  // The last stage is also the output register.
  assign level_ready = ~out_valid_q | out_ready_i;

  // Zero saturation needs no special arm: p, q and t all round back to the
  // brightness, so every sector gives grey.
  always_comb begin
    unique case (level_data.sector)
      SecRed: begin
        out_data_d = '{red: level_data.val, green: level_data.t, blue: level_data.p};
      end
      SecYellow: begin
        out_data_d = '{red: level_data.q, green: level_data.val, blue: level_data.p};
      end
      SecGreen: begin
        out_data_d = '{red: level_data.p, green: level_data.val, blue: level_data.t};
      end
      SecCyan: begin
        out_data_d = '{red: level_data.p, green: level_data.q, blue: level_data.val};
      end
      SecBlue: begin
        out_data_d = '{red: level_data.t, green: level_data.p, blue: level_data.val};
      end
      default: begin
        out_data_d = '{red: level_data.val, green: level_data.p, blue: level_data.q};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (level_ready) begin
      out_valid_q <= level_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (level_valid && level_ready) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
